// ===== rtl/pbct_pkg.sv =====
package pbct_pkg;

    localparam logic [5:0] TIME_MAX = 6'd59;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_PAUSE = 2'd2;
    localparam logic [1:0] MODE_RESET = 2'd3;

    localparam logic [1:0] PH_NONE   = 2'd0;
    localparam logic [1:0] PH_SETTLE = 2'd1;
    localparam logic [1:0] PH_SET    = 2'd2;
    localparam logic [1:0] PH_START  = 2'd3;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SEC   = 3'd3;

    localparam logic [3:0] SETTLE_RST     = 4'd4;
    localparam logic [3:0] REPEAT_RST     = 4'd4;
    localparam logic [7:0] LONG_PRESS_RST = 8'd31;
    localparam logic [3:0] HALF_SEC_RST   = 4'd5;

    typedef struct packed {
        logic btn_minutes;
        logic btn_seconds;
        logic btn_start;
    } t_in;

    typedef struct packed {
        logic [5:0] minutes_shown;
        logic [5:0] seconds_shown;
        logic       led_on;
        logic       alarm_on;
        logic [1:0] run_mode;
    } t_out;

    typedef struct packed {
        logic [3:0] settle_ticks;
        logic [3:0] repeat_ticks;
        logic [7:0] long_press_ticks;
        logic [3:0] half_second_ticks;
    } t_cfg;

    typedef struct packed {
        logic [5:0] minute_count;
        logic [5:0] second_count;
        logic [1:0] mode;
        logic       alarm_flag;
        logic [4:0] blink_phase_count;
        logic [1:0] press_phase;
        logic [7:0] press_tick_count;
    } t_state;

    function automatic logic [5:0] wrap_inc(input logic [5:0] v);
        return (v >= TIME_MAX) ? 6'd0 : v + 6'd1;
    endfunction

endpackage

// ===== rtl/pbct_step.sv =====
module pbct_step (
    input  pbct_pkg::t_state i_state,
    input  pbct_pkg::t_in    i_btn,
    input  pbct_pkg::t_cfg   i_cfg,
    output pbct_pkg::t_state o_state,
    output pbct_pkg::t_out   o_res
);
    import pbct_pkg::*;

    t_state     s;
    logic       bm;
    logic       bs;
    logic       bt;
    logic       any_btn;
    logic [3:0] half_len;
    logic [3:0] rep_len;
    logic [5:0] full_len;
    logic [4:0] blink_inc;
    logic       led;

    always_comb begin
        bm       = i_btn.btn_minutes & ~i_btn.btn_seconds & ~i_btn.btn_start;
        bs       = ~i_btn.btn_minutes & i_btn.btn_seconds & ~i_btn.btn_start;
        bt       = ~i_btn.btn_minutes & ~i_btn.btn_seconds & i_btn.btn_start;
        any_btn  = i_btn.btn_minutes | i_btn.btn_seconds | i_btn.btn_start;
        half_len = (i_cfg.half_second_ticks == 4'd0) ? 4'd1 : i_cfg.half_second_ticks;
        rep_len  = (i_cfg.repeat_ticks == 4'd0) ? 4'd1 : i_cfg.repeat_ticks;
        full_len = {1'b0, half_len, 1'b0};
        blink_inc = i_state.blink_phase_count + 5'd1;

        s = i_state;

        // blink and countdown
        if (s.mode == MODE_RUN || s.mode == MODE_PAUSE) begin
            s.blink_phase_count = blink_inc;
            if ({1'b0, blink_inc} >= full_len) begin
                s.blink_phase_count = 5'd0;
                if (s.mode == MODE_RUN) begin
                    if (s.second_count != 6'd0) begin
                        s.second_count = s.second_count - 6'd1;
                    end else if (s.minute_count != 6'd0) begin
                        s.second_count = TIME_MAX;
                        s.minute_count = s.minute_count - 6'd1;
                    end else begin
                        s.mode       = MODE_IDLE;
                        s.alarm_flag = 1'b1;
                    end
                end
            end
        end

        // press start
        if (s.press_phase == PH_NONE && any_btn) begin
            if (s.mode == MODE_RESET) begin
                s.mode = MODE_IDLE;
            end
            s.press_phase      = PH_SETTLE;
            s.press_tick_count = 8'd0;
        end

        if (s.press_phase == PH_SETTLE) begin
            if (s.press_tick_count >= {4'd0, i_cfg.settle_ticks}) begin
                if (bm || bs) begin
                    if (bm) begin
                        s.minute_count = wrap_inc(s.minute_count);
                    end else begin
                        s.second_count = wrap_inc(s.second_count);
                    end
                    s.alarm_flag       = 1'b0;
                    s.press_phase      = PH_SET;
                    s.press_tick_count = 8'd0;
                end else if (bt) begin
                    s.press_phase      = PH_START;
                    s.press_tick_count = 8'd1;
                end else begin
                    s.press_phase      = PH_NONE;
                    s.press_tick_count = 8'd0;
                end
            end else begin
                s.press_tick_count = s.press_tick_count + 8'd1;
            end
        end else if (s.press_phase == PH_SET && (bm || bs)) begin
            // auto repeat
            s.press_tick_count = s.press_tick_count + 8'd1;
            if (s.press_tick_count >= {4'd0, rep_len}) begin
                s.press_tick_count = 8'd0;
                if (bm) begin
                    s.minute_count = wrap_inc(s.minute_count);
                end else begin
                    s.second_count = wrap_inc(s.second_count);
                end
                s.alarm_flag = 1'b0;
            end
        end else if (s.press_phase == PH_START) begin
            if (bt) begin
                if (s.press_tick_count != 8'd255) begin
                    s.press_tick_count = s.press_tick_count + 8'd1;
                end
            end else begin
                if (s.press_tick_count <= i_cfg.long_press_ticks) begin
                    s.mode = (s.mode == MODE_RUN) ? MODE_PAUSE : MODE_RUN;
                end else begin
                    s.mode         = MODE_RESET;
                    s.minute_count = 6'd0;
                    s.second_count = 6'd0;
                    s.alarm_flag   = 1'b0;
                end
                s.blink_phase_count = 5'd0;
                s.press_phase       = PH_NONE;
                s.press_tick_count  = 8'd0;
            end
        end else if (s.press_phase == PH_SET) begin
            // set hold lost its single button
            if (bt) begin
                s.press_phase      = PH_START;
                s.press_tick_count = 8'd1;
            end else begin
                s.press_phase      = PH_NONE;
                s.press_tick_count = 8'd0;
            end
        end

        if (s.mode == MODE_RUN || s.mode == MODE_PAUSE) begin
            led = (s.blink_phase_count < {1'b0, half_len});
        end else begin
            led = s.alarm_flag;
        end

        o_state             = s;
        o_res.minutes_shown = s.minute_count;
        o_res.seconds_shown = s.second_count;
        o_res.led_on        = led;
        o_res.alarm_on      = s.alarm_flag;
        o_res.run_mode      = s.mode;
    end

endmodule

// ===== rtl/push_button_countdown_timer.sv =====
// output: a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle while o_in_stall is low, set by the single state update per tick
// a stalled result holds the request side off only while the result register is full
// reset: synchronous active-low i_rst_n; timer 00:00 idle, no press, config registers to defaults
module push_button_countdown_timer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  pbct_pkg::t_in                       i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output pbct_pkg::t_out                      o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    input  logic [pbct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    output logic                                o_cfg_ready
);
    import pbct_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_out   r_out;
    t_out   n_out;
    logic   r_out_valid;
    logic   in_take;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_take     = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pbct_step u_step (
        .i_state (r_state),
        .i_btn   (i_in_data),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks      <= SETTLE_RST;
            r_cfg.repeat_ticks      <= REPEAT_RST;
            r_cfg.long_press_ticks  <= LONG_PRESS_RST;
            r_cfg.half_second_ticks <= HALF_SEC_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SETTLE:     r_cfg.settle_ticks      <= i_cfg_data[3:0];
                REG_REPEAT:     r_cfg.repeat_ticks      <= i_cfg_data[3:0];
                REG_LONG_PRESS: r_cfg.long_press_ticks  <= i_cfg_data;
                REG_HALF_SEC:   r_cfg.half_second_ticks <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.minute_count      <= 6'd0;
            r_state.second_count      <= 6'd0;
            r_state.mode              <= MODE_IDLE;
            r_state.alarm_flag        <= 1'b0;
            r_state.blink_phase_count <= 5'd0;
            r_state.press_phase       <= PH_NONE;
            r_state.press_tick_count  <= 8'd0;
            r_out_valid               <= 1'b0;
        end else begin
            if (in_take) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/pbct_checker.sv =====
module pbct_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input pbct_pkg::t_out o_out_data,
    input logic           i_out_stall
);
    import pbct_pkg::*;

    // result stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // request side only stalls behind a full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.minutes_shown <= TIME_MAX
                        && o_out_data.seconds_shown <= TIME_MAX)
        else $error("time value out of range");

    a_led_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.run_mode == MODE_IDLE || o_out_data.run_mode == MODE_RESET)
        |-> o_out_data.led_on == o_out_data.alarm_on)
        else $error("led not steady outside counting");

    a_reset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.run_mode == MODE_RESET
        |-> o_out_data.minutes_shown == 6'd0 && o_out_data.seconds_shown == 6'd0
            && !o_out_data.alarm_on)
        else $error("reset mode with nonzero time or alarm");

endmodule

bind push_button_countdown_timer pbct_checker u_pbct_checker (.*);
